>>> rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants for the Miller-Rabin round engine
// Operand width, counter width, status codes and the FSM state type.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // operand width of candidate and witness
  localparam int NUM_BITS = 63;
  // counter wide enough to hold NUM_BITS itself
  localparam int CNT_W = $clog2(NUM_BITS + 1);

  // result status codes
  localparam logic [1:0] STATUS_PRIME     = 2'd0;
  localparam logic [1:0] STATUS_COMPOSITE = 2'd1;
  localparam logic [1:0] STATUS_BAD_WIT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_POW,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_CHECK,
    ST_SQR,
    ST_DONE
  } mrr_state_t;

  // control into the modular multiplier
  typedef struct packed {
    logic start;
  } mrr_mm_ctl_t;

  // status out of the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mrr_mm_stat_t;

endpackage

>>> rtl/mrr_cell.sv
// ----------------------------------------------------------------------------
// mrr_cell: one bit cell of the multiplier operand chain
// Loads its bit on start, otherwise takes the bit of its upper neighbor.
// ----------------------------------------------------------------------------
module mrr_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic shift_in,
  output logic q
);

  logic q_r;

  // load or shift down one place every cycle
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= load_bit;
    end else begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul: serial add-and-double modular multiplier
// Computes a*b mod m, one bit of b per cycle from a chain
// of bit cells that hands the operand down toward bit 0.
// ----------------------------------------------------------------------------
module mrr_modmul import mrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mrr_mm_ctl_t         ctl,
  input  logic [NUM_BITS-1:0] op_a,
  input  logic [NUM_BITS-1:0] op_b,
  input  logic [NUM_BITS-1:0] modulus,
  output mrr_mm_stat_t        stat,
  output logic [NUM_BITS-1:0] result
);

  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] dbl_r, dbl_nxt;
  logic [NUM_BITS-1:0] m_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [NUM_BITS-1:0] chain_q;

  // operand chain: bit 0 is the current multiplier bit
  for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
    logic shift_in;
    if (i == NUM_BITS - 1) begin : g_top
      assign shift_in = 1'b0;
    end else begin : g_mid
      assign shift_in = chain_q[i+1];
    end
    mrr_cell u_cell (
      .clk      (clk),
      .load     (ctl.start),
      .load_bit (op_b[i]),
      .shift_in (shift_in),
      .q        (chain_q[i])
    );
  end

  // (x + y) mod m for x, y < m
  function automatic logic [NUM_BITS-1:0] add_mod(
    input logic [NUM_BITS-1:0] x,
    input logic [NUM_BITS-1:0] y,
    input logic [NUM_BITS-1:0] m
  );
    logic [NUM_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[NUM_BITS-1:0];
  endfunction

  // accumulate and double one bit per cycle
  always_comb begin
    acc_nxt  = acc_r;
    dbl_nxt  = dbl_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      acc_nxt = '0;
      dbl_nxt = op_a;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (chain_q[0]) begin
        acc_nxt = add_mod(acc_r, dbl_r, m_r);
      end
      dbl_nxt = add_mod(dbl_r, dbl_r, m_r);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dbl_r <= dbl_nxt;
    cnt_r <= cnt_nxt;
    if (ctl.start) begin
      m_r <= modulus;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

>>> rtl/miller_rabin_primality_round.sv
// Throughput: one round at a time; the serial add-and-double multiplier sets it.
// Trivial candidates and bad witnesses skip the split and power steps and go straight to the verdict.
// Reset (rst_n low, synchronous) clears the sticky flags, the FSM and out_valid.
// ----------------------------------------------------------------------------
// miller_rabin_primality_round: one Miller-Rabin round per item
// Splits candidate-1, raises the witness to the odd part, squares, and
// collects a sticky verdict that is given on the last round.
// ----------------------------------------------------------------------------
module miller_rabin_primality_round import mrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUM_BITS-1:0] in_candidate,
  input  logic [NUM_BITS-1:0] in_witness,
  input  logic                in_last_round,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status
);

  mrr_state_t          state_r, state_nxt;
  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [NUM_BITS-1:0] nm1_r, nm1_nxt;
  logic [NUM_BITS-1:0] d_r, d_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] base_r, base_nxt;
  logic [NUM_BITS-1:0] opa_r, opa_nxt;
  logic [NUM_BITS-1:0] opb_r, opb_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                last_r, last_nxt;
  logic                fail_r, fail_nxt;
  logic                bad_r, bad_nxt;
  logic                comp_seen_r, comp_seen_nxt;
  logic                bad_seen_r, bad_seen_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                go_r, go_nxt;
  logic                acc_in;
  logic                trivial;
  logic                slot_free;
  logic                comp_all, bad_all;
  logic [CNT_W-1:0]    cnt_dec;
  mrr_mm_ctl_t         mm_ctl;
  mrr_mm_stat_t        mm_stat;
  logic [NUM_BITS-1:0] mm_res;

  assign mm_ctl.start = go_r;

  mrr_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mm_ctl),
    .op_a    (opa_r),
    .op_b    (opb_r),
    .modulus (n_r),
    .stat    (mm_stat),
    .result  (mm_res)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign acc_in     = in_valid && !in_stall;
  assign trivial    = (in_candidate < NUM_BITS'(2)) ||
                      ((in_candidate != NUM_BITS'(2)) && !in_candidate[0]);
  assign slot_free  = !out_valid_r || !out_stall;
  assign comp_all   = comp_seen_r || fail_r;
  assign bad_all    = bad_seen_r || bad_r;
  assign cnt_dec    = cnt_r - 1'b1;

  // sequence one round through split, power and squarings
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    nm1_nxt        = nm1_r;
    d_nxt          = d_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    fail_nxt       = fail_r;
    bad_nxt        = bad_r;
    comp_seen_nxt  = comp_seen_r;
    bad_seen_nxt   = bad_seen_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    go_nxt         = 1'b0;

    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          n_nxt    = in_candidate;
          nm1_nxt  = in_candidate - 1'b1;
          d_nxt    = in_candidate - 1'b1;
          base_nxt = in_witness;
          acc_nxt  = NUM_BITS'(1);
          cnt_nxt  = '0;
          last_nxt = in_last_round;
          fail_nxt = 1'b0;
          bad_nxt  = 1'b0;
          if (trivial) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if ((in_witness == '0) || (in_witness >= in_candidate)) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        // strip one factor of two per cycle
        if (!d_r[0]) begin
          d_nxt   = d_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (d_r == '0) begin
          state_nxt = ST_CHECK;
        end else if (d_r[0]) begin
          opa_nxt   = acc_r;
          opb_nxt   = base_r;
          go_nxt    = 1'b1;
          state_nxt = ST_POW_MUL;
        end else begin
          opa_nxt   = base_r;
          opb_nxt   = base_r;
          go_nxt    = 1'b1;
          state_nxt = ST_POW_SQ;
        end
      end
      ST_POW_MUL: begin
        if (mm_stat.done) begin
          acc_nxt   = mm_res;
          opa_nxt   = base_r;
          opb_nxt   = base_r;
          go_nxt    = 1'b1;
          state_nxt = ST_POW_SQ;
        end
      end
      ST_POW_SQ: begin
        if (mm_stat.done) begin
          base_nxt  = mm_res;
          d_nxt     = d_r >> 1;
          state_nxt = ST_POW;
        end
      end
      ST_CHECK: begin
        if ((acc_r == NUM_BITS'(1)) || (acc_r == nm1_r)) begin
          state_nxt = ST_DONE;
        end else if (cnt_r <= CNT_W'(1)) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          opa_nxt   = acc_r;
          opb_nxt   = acc_r;
          go_nxt    = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          cnt_nxt = cnt_dec;
          if (mm_res == nm1_r) begin
            state_nxt = ST_DONE;
          end else if ((mm_res == NUM_BITS'(1)) || (cnt_dec <= CNT_W'(1))) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            opa_nxt = mm_res;
            opb_nxt = mm_res;
            go_nxt  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        // fold the round into the flags, give the verdict on the last round
        if (!last_r) begin
          comp_seen_nxt = comp_all;
          bad_seen_nxt  = bad_all;
          state_nxt     = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (bad_all) begin
            out_status_nxt = STATUS_BAD_WIT;
          end else if (comp_all) begin
            out_status_nxt = STATUS_COMPOSITE;
          end else begin
            out_status_nxt = STATUS_PRIME;
          end
          comp_seen_nxt = 1'b0;
          bad_seen_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold payload
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    nm1_r        <= nm1_nxt;
    d_r          <= d_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    cnt_r        <= cnt_nxt;
    last_r       <= last_nxt;
    fail_r       <= fail_nxt;
    bad_r        <= bad_nxt;
    out_status_r <= out_status_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      comp_seen_r <= 1'b0;
      bad_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      comp_seen_r <= comp_seen_nxt;
      bad_seen_r  <= bad_seen_nxt;
      out_valid_r <= out_valid_nxt;
      go_r        <= go_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // multiplier finishes only while a product is awaited
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == ST_POW_MUL || state_r == ST_POW_SQ ||
                      state_r == ST_SQR))
    else $error("multiplier done outside a product state");

  // no new product is started while one runs
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  // split never sees a zero value
  a_split_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |-> (d_r != '0))
    else $error("split reached zero");

  // a shown result never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != 2'd3))
    else $error("invalid status code");

endmodule
